@@ hw/rtl/ppmhp_pkg.sv @@
package ppmhp_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_WIDTH  = 3'd1,
    PH_HEIGHT = 3'd2,
    PH_MAXVAL = 3'd3,
    PH_PIXELS = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  localparam logic [1:0] ST_HEADER = 2'd0;
  localparam logic [1:0] ST_PIXEL  = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MAGIC    = 3'd1;
  localparam logic [2:0] ERR_WIDTH    = 3'd2;
  localparam logic [2:0] ERR_HEIGHT   = 3'd3;
  localparam logic [2:0] ERR_MAXVAL   = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_P     = 8'd80;
  localparam logic [7:0] CH_SIX   = 8'd54;

  typedef struct packed {
    phase_t      phase;
    logic        in_gap;
    logic        in_comment;
    logic [16:0] token_value;
    logic        token_numeric;
    logic        magic_ok;
    logic [16:0] width_store;
    logic [16:0] height_store;
    logic [15:0] maxval_store;
    logic [2:0]  error_store;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:         PH_MAGIC,
    in_gap:        1'b0,
    in_comment:    1'b0,
    token_value:   17'd0,
    token_numeric: 1'b1,
    magic_ok:      1'b1,
    width_store:   17'd0,
    height_store:  17'd0,
    maxval_store:  16'd0,
    error_store:   ERR_NONE
  };

endpackage

@@ hw/rtl/ppmhp_step.sv @@
module ppmhp_step import ppmhp_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = 5,
  parameter int LEN_W = 3
) (
  input  parse_state_t     cur,
  input  logic [LEN_W-1:0] cur_len,
  input  logic [7:0]       byte_in,
  input  logic             frame_start,
  output parse_state_t     nxt,
  output logic [LEN_W-1:0] nxt_len,
  output logic [1:0]       status,
  output logic [7:0]       pixel_byte
);

  parse_state_t     s;
  logic [LEN_W-1:0] len;
  logic             ws;
  logic             is_digit;
  logic             do_add;
  logic             do_end;
  logic [16:0]      base_value;
  logic             base_numeric;
  logic             base_magic;
  logic [LEN_W-1:0] base_len;
  logic [16:0]      times_ten;

  always_comb begin
    s   = frame_start ? PARSE_RESET : cur;
    len = frame_start ? '0 : cur_len;
    nxt = s;
    nxt_len = len;
    status = ST_HEADER;
    pixel_byte = 8'd0;
    ws = (byte_in == CH_SPACE) || (byte_in == CH_TAB) ||
         (byte_in == CH_CR) || (byte_in == CH_LF);
    is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    do_add = 1'b0;
    do_end = 1'b0;
    base_value = s.token_value;
    base_numeric = s.token_numeric;
    base_magic = s.magic_ok;
    base_len = len;

    case (s.phase)
      PH_PIXELS: begin
        status = ST_PIXEL;
        pixel_byte = byte_in;
      end
      PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (s.in_gap) begin
          if (s.in_comment) begin
            if (byte_in == CH_LF) begin
              nxt.in_comment = 1'b0;
            end
          end else if (!ws) begin
            if (byte_in == CH_HASH) begin
              nxt.in_comment = 1'b1;
            end else begin
              // First byte of a new token: start from a clean token.
              nxt.in_gap = 1'b0;
              base_value = 17'd0;
              base_numeric = 1'b1;
              base_magic = 1'b1;
              base_len = '0;
              do_add = 1'b1;
            end
          end
        end else if (ws) begin
          do_end = 1'b1;
        end else begin
          do_add = 1'b1;
        end
      end
      default: begin
      end
    endcase

    times_ten = {base_value[13:0], 3'b000} + {base_value[15:0], 1'b0};

    if (do_add) begin
      nxt.token_value = base_value;
      nxt.token_numeric = base_numeric;
      nxt.magic_ok = base_magic;
      nxt_len = base_len;
      if (base_len >= LEN_W'(MAX_TOKEN_CHARS)) begin
        nxt.phase = PH_ERROR;
        nxt.error_store = ERR_TOO_LONG;
      end else begin
        if (base_len == '0) begin
          if (byte_in != CH_P) nxt.magic_ok = 1'b0;
        end else if (base_len == LEN_W'(1)) begin
          if (byte_in != CH_SIX) nxt.magic_ok = 1'b0;
        end else begin
          nxt.magic_ok = 1'b0;
        end
        if (is_digit) begin
          nxt.token_value = times_ten + {13'd0, byte_in[3:0]};
        end else begin
          nxt.token_numeric = 1'b0;
        end
        nxt_len = base_len + LEN_W'(1);
      end
    end

    if (do_end) begin
      case (s.phase)
        PH_MAGIC: begin
          if (!s.magic_ok || (len != LEN_W'(2))) begin
            nxt.phase = PH_ERROR;
            nxt.error_store = ERR_MAGIC;
          end else begin
            nxt.phase = PH_WIDTH;
            nxt.in_gap = 1'b1;
            nxt.in_comment = 1'b0;
          end
        end
        PH_WIDTH: begin
          if (!s.token_numeric) begin
            nxt.phase = PH_ERROR;
            nxt.error_store = ERR_WIDTH;
          end else begin
            nxt.width_store = s.token_value;
            nxt.phase = PH_HEIGHT;
            nxt.in_gap = 1'b1;
            nxt.in_comment = 1'b0;
          end
        end
        PH_HEIGHT: begin
          if (!s.token_numeric) begin
            nxt.phase = PH_ERROR;
            nxt.error_store = ERR_HEIGHT;
          end else begin
            nxt.height_store = s.token_value;
            nxt.phase = PH_MAXVAL;
            nxt.in_gap = 1'b1;
            nxt.in_comment = 1'b0;
          end
        end
        default: begin
          // Maximum value must be numeric and below 65536.
          if (!s.token_numeric || s.token_value[16]) begin
            nxt.phase = PH_ERROR;
            nxt.error_store = ERR_MAXVAL;
          end else begin
            nxt.maxval_store = s.token_value[15:0];
            nxt.phase = PH_PIXELS;
          end
        end
      endcase
    end

    if (nxt.phase == PH_ERROR) begin
      status = ST_ERROR;
    end
  end

endmodule

@@ hw/rtl/ppm_p6_header_parser_core.sv @@
// PPM (P6) header parser. Bytes of a PPM file enter on the input channel
// (in_valid, in_stall, byte_in, frame_start), one word per byte; set
// frame_start on the first byte of each file to restart parsing.
// Every input word produces exactly one output word (out_valid, out_stall):
// status 0 while the header is still being read, 1 for a pixel byte that
// appears on pixel_byte, 2 once a header error is found. error_code and the
// parsed width, height and maximum value ride along with every word; an
// error holds until the next frame_start.
// The output word is registered: a byte accepted at one edge is offered on the
// output in the next cycle. Throughput is one byte per cycle, set by the
// single output register; a byte is accepted whenever that register is
// empty or is being taken in the same cycle.
// When the receiver stalls, the output word holds and in_stall rises, so
// at most one word is held back.
// Reset clears the parse state to "expecting magic" and empties the output
// register.
module ppm_p6_header_parser_core import ppmhp_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [2:0]  error_code,
  output logic [16:0] image_width,
  output logic [16:0] image_height,
  output logic [15:0] max_value,
  output logic [7:0]  pixel_byte
);

  localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);

  parse_state_t     state;
  parse_state_t     state_next;
  logic [LEN_W-1:0] token_len;
  logic [LEN_W-1:0] token_len_next;
  logic [1:0]       status_next;
  logic [7:0]       pixel_next;
  logic             accept;

  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  ppmhp_step #(
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS),
    .LEN_W(LEN_W)
  ) u_step (
    .cur(state),
    .cur_len(token_len),
    .byte_in(byte_in),
    .frame_start(frame_start),
    .nxt(state_next),
    .nxt_len(token_len_next),
    .status(status_next),
    .pixel_byte(pixel_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PARSE_RESET;
      token_len <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
        token_len <= token_len_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      error_code <= state_next.error_store;
      image_width <= state_next.width_store;
      image_height <= state_next.height_store;
      max_value <= state_next.maxval_store;
      pixel_byte <= pixel_next;
    end
  end

endmodule

@@ dv/ppm_header_checker.sv @@
module ppm_header_checker import ppmhp_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        frame_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [2:0]  error_code,
  input  logic [16:0] image_width,
  input  logic [16:0] image_height,
  input  logic [15:0] max_value,
  input  logic [7:0]  pixel_byte,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  error_code;
    logic [16:0] width;
    logic [16:0] height;
    logic [15:0] max_value;
    logic [7:0]  pixel;
  } header_word_t;

  // Shadow copy of the header parse state.
  phase_t      phase_q;
  logic        gap_q;
  logic        comment_q;
  int          tok_len;
  logic [16:0] tok_val;
  logic        tok_num;
  logic        magic_q;
  logic [16:0] width_q;
  logic [16:0] height_q;
  logic [15:0] maxval_q;
  logic [2:0]  err_q;

  header_word_t expected_words[$];
  header_word_t got_w;
  header_word_t want_w;

  function void clear_parse();
    phase_q   = PH_MAGIC;
    gap_q     = 1'b0;
    comment_q = 1'b0;
    tok_len   = 0;
    tok_val   = '0;
    tok_num   = 1'b1;
    magic_q   = 1'b1;
    width_q   = '0;
    height_q  = '0;
    maxval_q  = '0;
    err_q     = ERR_NONE;
  endfunction

  function void raise_error(logic [2:0] code);
    phase_q = PH_ERROR;
    err_q   = code;
  endfunction

  function void take_char(logic [7:0] b);
    logic [31:0] acc;
    if (tok_len >= MAX_TOKEN_CHARS) begin
      raise_error(ERR_TOO_LONG);
      return;
    end
    if (tok_len == 0) begin
      if (b != CH_P) magic_q = 1'b0;
    end else if (tok_len == 1) begin
      if (b != CH_SIX) magic_q = 1'b0;
    end else begin
      magic_q = 1'b0;
    end
    if (b >= CH_ZERO && b <= CH_NINE) begin
      acc = tok_val * 10 + (b - CH_ZERO);
      tok_val = acc[16:0];
    end else begin
      tok_num = 1'b0;
    end
    tok_len++;
  endfunction

  function header_word_t parse_byte(logic [7:0] b, logic fs);
    header_word_t w;
    logic ws;
    w = '0;
    if (fs) clear_parse();
    ws = (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF);
    if (phase_q == PH_PIXELS) begin
      w.status = ST_PIXEL;
      w.pixel  = b;
    end else if (phase_q != PH_ERROR) begin
      if (gap_q) begin
        if (comment_q) begin
          if (b == CH_LF) comment_q = 1'b0;
        end else if (!ws) begin
          if (b == CH_HASH) begin
            comment_q = 1'b1;
          end else begin
            gap_q   = 1'b0;
            tok_len = 0;
            tok_val = '0;
            tok_num = 1'b1;
            magic_q = 1'b1;
            take_char(b);
          end
        end
      end else if (ws) begin
        // Whitespace closes the current token.
        case (phase_q)
          PH_MAGIC: begin
            if (!magic_q || tok_len != 2) raise_error(ERR_MAGIC);
            else phase_q = PH_WIDTH;
          end
          PH_WIDTH: begin
            if (!tok_num) raise_error(ERR_WIDTH);
            else begin
              width_q = tok_val;
              phase_q = PH_HEIGHT;
            end
          end
          PH_HEIGHT: begin
            if (!tok_num) raise_error(ERR_HEIGHT);
            else begin
              height_q = tok_val;
              phase_q  = PH_MAXVAL;
            end
          end
          default: begin
            if (!tok_num || tok_val >= 17'h10000) raise_error(ERR_MAXVAL);
            else begin
              maxval_q = tok_val[15:0];
              phase_q  = PH_PIXELS;
            end
          end
        endcase
        // Only a finished token that leads to another one opens a gap.
        if (phase_q == PH_WIDTH || phase_q == PH_HEIGHT || phase_q == PH_MAXVAL) begin
          gap_q     = 1'b1;
          comment_q = 1'b0;
        end
      end else begin
        take_char(b);
      end
    end
    if (phase_q == PH_ERROR) w.status = ST_ERROR;
    w.error_code = err_q;
    w.width      = width_q;
    w.height     = height_q;
    w.max_value  = maxval_q;
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      expected_words.delete();
      mismatches = 0;
    end else begin
      // Outputs are checked before the new input is predicted, since a word
      // accepted at this edge cannot come out before the next one.
      if (out_valid && !out_stall) begin
        got_w = {status, error_code, image_width, image_height, max_value, pixel_byte};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: status=%0d code=%0d width=%0d height=%0d max=%0d pixel=%0d",
                     got_w.status, got_w.error_code, got_w.width, got_w.height,
                     got_w.max_value, got_w.pixel);
        end else begin
          want_w = expected_words.pop_front();
          if (got_w !== want_w) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch expected: st=%0d code=%0d w=%0d h=%0d max=%0d pix=%0d",
                       want_w.status, want_w.error_code, want_w.width, want_w.height,
                       want_w.max_value, want_w.pixel);
              $display("mismatch got:      st=%0d code=%0d w=%0d h=%0d max=%0d pix=%0d",
                       got_w.status, got_w.error_code, got_w.width, got_w.height,
                       got_w.max_value, got_w.pixel);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        expected_words.push_back(parse_byte(byte_in, frame_start));
    end
    pending = expected_words.size();
  end

endmodule

@@ dv/ppm_p6_header_parser_core_tb.sv @@
module ppm_p6_header_parser_core_tb import ppmhp_pkg::*; ();

  localparam int TOKEN_CHARS = 5;
  localparam int TOTAL_BYTES = 1750;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC, RX_HOLD} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  byte_in;
  logic        frame_start;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [2:0]  error_code;
  logic [16:0] image_width;
  logic [16:0] image_height;
  logic [15:0] max_value;
  logic [7:0]  pixel_byte;
  int          fail_count;
  int          pending;

  int          bytes_sent;
  int          burst_left;
  int          cycle_count;
  logic [7:0]  frame_q[$];

  ppm_p6_header_parser_core #(.MAX_TOKEN_CHARS(TOKEN_CHARS)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_in      (byte_in),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .error_code   (error_code),
    .image_width  (image_width),
    .image_height (image_height),
    .max_value    (max_value),
    .pixel_byte   (pixel_byte)
  );

  ppm_header_checker #(.MAX_TOKEN_CHARS(TOKEN_CHARS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_in      (byte_in),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .error_code   (error_code),
    .image_width  (image_width),
    .image_height (image_height),
    .max_value    (max_value),
    .pixel_byte   (pixel_byte),
    .mismatches   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("FAIL ppm_p6_header_parser_core");
    $finish;
  end

  // The receiver switches between stall patterns and holds off once for a
  // long stretch so that the block backs up into its input.
  initial begin
    rx_mode_t mode;
    int       seg_len;
    int       rx_cycles;
    logic     held;
    rx_cycles = 0;
    held = 1'b0;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(20, 200);
      if (!held && rx_cycles > 1000) begin
        mode = RX_HOLD;
        seg_len = 300;
        held = 1'b1;
      end
      repeat (seg_len) begin
        @(negedge clk);
        case (mode)
          RX_FREE:     out_stall <= 1'b0;
          RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_stall <= (rx_cycles % 3 == 0);
          default:     out_stall <= 1'b1;
        endcase
        rx_cycles++;
      end
    end
  end

  task push_byte(input logic [7:0] b, input logic fs);
    @(negedge clk);
    in_valid    <= 1'b1;
    byte_in     <= b;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 1) == 1) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end
    end
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == 0);
  endtask

  function logic [7:0] ws_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function logic [7:0] noise_char();
    case ($urandom_range(0, 3))
      0:       return CH_HASH;
      1:       return ws_char();
      2:       return 8'(CH_ZERO + $urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function int unsigned pick_dim(logic overlong);
    if (overlong && $urandom_range(0, 2) == 0) return $urandom_range(100000, 9999999);
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 99999;
      2:       return $urandom_range(1, 9);
      3:       return $urandom_range(10, 999);
      default: return $urandom_range(0, 99999);
    endcase
  endfunction

  function int unsigned pick_maxval(logic overlong);
    if (overlong && $urandom_range(0, 2) == 0) return $urandom_range(100000, 9999999);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      2:       return 65535;
      3:       return 65536;
      4:       return 99999;
      default: return $urandom_range(0, 99999);
    endcase
  endfunction

  // The rest of a separator run after its first whitespace byte: up to two more whitespace bytes or comments.
  task add_gap();
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 2) == 0) begin
        frame_q.push_back(CH_HASH);
        repeat ($urandom_range(0, 4)) begin
          frame_q.push_back(8'($urandom_range(0, 255)));
          if (frame_q[$] == CH_LF) frame_q[$] = CH_SPACE;
        end
        frame_q.push_back(CH_LF);
      end else begin
        frame_q.push_back(ws_char());
      end
    end
  endtask

  task add_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if (s.len() < TOKEN_CHARS && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, TOKEN_CHARS - s.len())) frame_q.push_back(CH_ZERO);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  // Mostly well-formed files with random values, some damaged, some noise.
  task build_frame();
    int   kind;
    int   hdr_len;
    int   cut;
    logic broken;
    frame_q.delete();
    kind = $urandom_range(0, 9);
    broken = (kind <= 2);
    if (kind == 0) begin
      repeat ($urandom_range(1, 24)) frame_q.push_back(noise_char());
    end else begin
      if (broken && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) frame_q.push_back(noise_char());
      end else begin
        frame_q.push_back(CH_P);
        frame_q.push_back(CH_SIX);
      end
      frame_q.push_back(ws_char());
      add_gap();
      add_number(pick_dim(broken));
      frame_q.push_back(ws_char());
      add_gap();
      add_number(pick_dim(broken));
      frame_q.push_back(ws_char());
      add_gap();
      add_number(pick_maxval(broken));
      frame_q.push_back(ws_char());
      hdr_len = frame_q.size();
      repeat ($urandom_range(0, 24)) frame_q.push_back(8'($urandom_range(0, 255)));
      if (broken) begin
        repeat ($urandom_range(0, 2)) frame_q[$urandom_range(0, hdr_len - 1)] = noise_char();
        if ($urandom_range(0, 3) == 0) begin
          cut = $urandom_range(1, hdr_len);
          while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
      end
    end
  endtask

  initial begin
    logic restart;
    rst = 1'b1;
    in_valid = 1'b0;
    byte_in = '0;
    frame_start = 1'b0;
    bytes_sent = 0;
    burst_left = $urandom_range(1, 48);
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Leading whitespace is bad magic, and the error holds for later bytes.
    send_text(" ");
    push_byte(8'hFF, 1'b0);
    // Comment in a gap, CR and tab separators, zero height and maximum value,
    // then whitespace, hash and extreme bytes as pixel data.
    send_text("P6\t#\n1\0150 0\n");
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_HASH, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    // A six digit width runs past the token limit.
    send_text("P6 123456");

    while (bytes_sent < TOTAL_BYTES) begin
      build_frame();
      restart = ($urandom_range(0, 9) != 0);
      foreach (frame_q[i]) push_byte(frame_q[i], restart && i == 0);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS ppm_p6_header_parser_core");
    end else begin
      $display("FAIL ppm_p6_header_parser_core");
    end
    $finish;
  end

endmodule
